@@ rtl/core/pnlr_pkg.sv @@
// Shared types and constants for the pump node link responder.
package pnlr_pkg;

   localparam logic [2:0] KIND_TX      = 3'd0;
   localparam logic [2:0] KIND_JOINED  = 3'd1;
   localparam logic [2:0] KIND_COMMAND = 3'd2;
   localparam logic [2:0] KIND_BAD_CRC = 3'd3;
   localparam logic [2:0] KIND_FOREIGN = 3'd4;
   localparam logic [2:0] KIND_IGNORED = 3'd5;
   localparam logic [2:0] KIND_BAD_LEN = 3'd6;

   localparam logic [2:0] REG_MASTER_ID  = 3'd0;
   localparam logic [2:0] REG_PUMP_ID    = 3'd1;
   localparam logic [2:0] REG_ADC_ONE    = 3'd2;
   localparam logic [2:0] REG_ADC_FOUR   = 3'd3;
   localparam logic [2:0] REG_SUPPRESS   = 3'd4;
   localparam logic [2:0] REG_JOIN_RETRY = 3'd5;

   localparam logic [7:0] PROTO_VER  = 8'h01;
   localparam logic [7:0] T_JOIN_REQ = 8'h01;
   localparam logic [7:0] T_JOIN_ACC = 8'h02;
   localparam logic [7:0] T_LEVEL    = 8'h10;
   localparam logic [7:0] T_ACK      = 8'h11;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [7:0] SLOT_NONE  = 8'hFF;
   localparam int MIN_PACKET = 10;
   localparam int HDR_DEPTH  = 11;

   // Work handed from the front to the back.
   typedef struct packed {
      logic [2:0] kind;     // status result kind, or KIND_TX for a join request
      logic       send_ack; // command followed by an ack frame
      logic       send_join;// tick that sends a join request
      logic       level;
      logic [7:0] seq;
      logic [7:0] slot;
      logic [31:0] bad_crc;
      logic [31:0] foreign;
      logic [31:0] cmds;
      logic [31:0] acks;
   } job_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/pnlr_front.sv @@
// Front end: packet parsing, checks, link state and counters.
module pnlr_front import pnlr_pkg::*; #(
   parameter int MaxPacket = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        action,
   input  logic [7:0]  rx_byte,
   input  logic        rx_last,
   input  logic [31:0] master_id,
   input  logic [15:0] pump_id,
   input  logic        suppress_ack,
   input  logic [15:0] join_retry_ticks,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job
);
   localparam int CW = $clog2(MaxPacket + 2);

   logic [7:0]  hdr_ff [HDR_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        joined_ff, joined_in;
   logic [7:0]  slot_ff, slot_in;
   logic [15:0] timer_ff, timer_in;
   logic [31:0] badc_ff, badc_in, forc_ff, forc_in, cmdc_ff, cmdc_in, ackc_ff, ackc_in;
   logic        jv_ff, jv_in;
   job_type     job_ff, job_in;

   logic [15:0] crc_next;
   logic [31:0] mid;
   logic [7:0]  h [HDR_DEPTH];

   assign in_ready  = !jv_ff || job_ready;
   assign job_valid = jv_ff;
   assign job       = job_ff;
   assign crc_next  = crc_byte(crc_ff, rx_byte);

   // header view including the byte arriving now
   always_comb begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         h[i] = (count_ff == CW'(i)) ? rx_byte : hdr_ff[i];
      end
   end
   assign mid = {h[2], h[3], h[4], h[5]};

   always_comb begin
      logic [CW-1:0] len;
      count_in = count_ff; crc_in = crc_ff; joined_in = joined_ff; slot_in = slot_ff;
      timer_in = timer_ff; badc_in = badc_ff; forc_in = forc_ff; cmdc_in = cmdc_ff;
      ackc_in = ackc_ff;
      jv_in = jv_ff && !job_ready;
      job_in = job_ff;
      len = (count_ff <= CW'(MaxPacket)) ? count_ff + CW'(1) : count_ff;
      if (in_valid && in_ready) begin
         job_in.kind = KIND_IGNORED; job_in.send_ack = 1'b0; job_in.send_join = 1'b0;
         job_in.level = 1'b0; job_in.seq = '0;
         if (action) begin
            if (!joined_ff) begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 16'd1;
               end else begin
                  timer_in = join_retry_ticks;
                  job_in.send_join = 1'b1;
                  job_in.kind = KIND_TX;
                  jv_in = 1'b1;
               end
            end
         end else begin
            count_in = len;
            crc_in = crc_next;
            if (rx_last) begin
               count_in = '0;
               crc_in = CRC_INIT;
               jv_in = 1'b1;
               priority if (len < CW'(MIN_PACKET) || len > CW'(MaxPacket)) begin
                  job_in.kind = KIND_BAD_LEN;
               end else if (crc_next != '0) begin
                  job_in.kind = KIND_BAD_CRC;
                  badc_in = badc_ff + 32'd1;
               end else if (h[0] != PROTO_VER || mid != master_id) begin
                  job_in.kind = KIND_FOREIGN;
                  forc_in = forc_ff + 32'd1;
               end else if (!joined_ff) begin
                  if (h[1] == T_JOIN_ACC && len >= CW'(13) && {h[8], h[9]} == pump_id) begin
                     slot_in = h[10];
                     joined_in = 1'b1;
                     job_in.kind = KIND_JOINED;
                  end
               end else if (h[1] == T_LEVEL && h[6] == slot_ff) begin
                  job_in.kind = KIND_COMMAND;
                  job_in.level = h[8] != '0;
                  job_in.seq = h[7];
                  cmdc_in = cmdc_ff + 32'd1;
                  if (!suppress_ack) begin
                     job_in.send_ack = 1'b1;
                     ackc_in = ackc_ff + 32'd1;
                  end
               end
            end
         end
         job_in.slot = slot_in; job_in.bad_crc = badc_in; job_in.foreign = forc_in;
         job_in.cmds = cmdc_in; job_in.acks = ackc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; crc_ff <= CRC_INIT; joined_ff <= 1'b0; slot_ff <= SLOT_NONE;
         timer_ff <= '0; badc_ff <= '0; forc_ff <= '0; cmdc_ff <= '0; ackc_ff <= '0;
         jv_ff <= 1'b0;
      end else begin
         count_ff <= count_in; crc_ff <= crc_in; joined_ff <= joined_in; slot_ff <= slot_in;
         timer_ff <= timer_in; badc_ff <= badc_in; forc_ff <= forc_in; cmdc_ff <= cmdc_in;
         ackc_ff <= ackc_in; jv_ff <= jv_in;
      end
      job_ff <= job_in;
      if (in_valid && in_ready && !action && count_ff < CW'(HDR_DEPTH)) begin
         hdr_ff[count_ff[$clog2(HDR_DEPTH)-1:0]] <= rx_byte;
      end
   end
endmodule

@@ rtl/core/pnlr_queue.sv @@
// Two-entry job queue between front and back.
module pnlr_queue import pnlr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_job
);
   job_type     mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_job   = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= wr_job;
   end
endmodule

@@ rtl/core/pnlr_back.sv @@
// Back end: emits status results and serializes join and ack frames.
module pnlr_back import pnlr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   input  logic [31:0] master_id,
   input  logic [15:0] pump_id,
   input  logic [15:0] adc_one,
   input  logic [15:0] adc_four,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [2:0]  kind,
   output logic [7:0]  tx_byte,
   output logic        run_last,
   output logic [7:0]  slot_number,
   output logic        command_state,
   output logic [7:0]  sequence_res
);
   // step 0 is the status result (skipped for a join request), then frame bytes
   logic [4:0]  step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic [4:0]  flen;
   logic [4:0]  bidx;
   logic [7:0]  fb;
   logic        is_status, last;

   assign is_status = !job.send_join && step_ff == 5'd0;
   assign bidx = job.send_join ? step_ff : step_ff - 5'd1;
   assign flen = job.send_join ? 5'd12 : 5'd17;

   always_comb begin
      unique case (bidx)
         5'd0:  fb = PROTO_VER;
         5'd1:  fb = job.send_join ? T_JOIN_REQ : T_ACK;
         5'd2:  fb = master_id[31:24];
         5'd3:  fb = master_id[23:16];
         5'd4:  fb = master_id[15:8];
         5'd5:  fb = master_id[7:0];
         5'd6:  fb = job.send_join ? SLOT_NONE : job.slot;
         5'd7:  fb = job.send_join ? 8'h00 : job.seq;
         5'd8:  fb = job.send_join ? pump_id[15:8] : {7'd0, job.level};
         5'd9:  fb = job.send_join ? pump_id[7:0] : 8'h00;
         5'd10: fb = job.send_join ? crc_ff[15:8] : 8'h00;
         5'd11: fb = job.send_join ? crc_ff[7:0] : adc_one[15:8];
         5'd12: fb = adc_one[7:0];
         5'd13: fb = adc_four[15:8];
         5'd14: fb = adc_four[7:0];
         5'd15: fb = crc_ff[15:8];
         5'd16: fb = crc_ff[7:0];
         default: fb = 8'h00;
      endcase
   end

   assign last = is_status ? !job.send_ack : (bidx == flen - 5'd1);
   assign out_valid     = job_valid;
   assign job_ready     = out_ready && last;
   assign kind          = is_status ? job.kind : KIND_TX;
   assign tx_byte       = is_status ? 8'h00 : fb;
   assign run_last      = last;
   assign slot_number   = job.slot;
   assign command_state = job.send_join ? 1'b0 : job.level;
   assign sequence_res  = job.send_join ? 8'h00 : job.seq;

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      if (job_valid && out_ready) begin
         if (last) begin
            step_in = '0;
            crc_in  = CRC_INIT;
         end else begin
            step_in = step_ff + 5'd1;
            if (!is_status && bidx < flen - 5'd2) crc_in = crc_byte(crc_ff, fb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0; crc_ff <= CRC_INIT;
      end else begin
         step_ff <= step_in; crc_ff <= crc_in;
      end
   end
endmodule

@@ rtl/core/pump_node_link_responder.sv @@
// Top level of the pump node link responder.
// Requests arrive on req_: tuser is action (0 byte, 1 tick), tdata the
// received byte, tlast closes a packet. Results leave on rsp_: tuser is the
// kind, tlast marks the last result caused by one request, tdata carries
// tx_byte, slot_number, command_state, sequence_res and four 32-bit totals.
// The front accepts one request per cycle, checks packets and updates link
// state and counters; it needs the two-entry job queue to have room.
// A request that yields results is registered in the front, then in the queue.
// The back emits one result per cycle while rsp_tready is high: one for a
// status, 12 for a join request, 18 for a command with its acknowledgement;
// frame length at the back port sets the sustained rate, so plain bytes and
// ticks go at one per cycle while packet ends cost up to 18 results.
// Reset clears the link (not joined, slot 255, join timer expired so the
// first tick sends), counters and registers to their defaults.
// A stalled rsp_tready holds the current result; the queue then fills and
// req_tready drops. csr_ writes go to register csr_index.
module pump_node_link_responder import pnlr_pkg::*; #(
   parameter int MaxPacket = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // rx_byte
   input  logic         req_tuser,  // action
   input  logic         req_tlast,  // rx_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,  // tx_byte, slot_number, command_state, sequence_res,
                                    // bad_crc_total, foreign_total, command_total,
                                    // ack_total, 7 zero bits
   output logic [2:0]   rsp_tuser,  // kind
   output logic         rsp_tlast,  // run_last
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   logic [31:0] master_id_ff;
   logic [15:0] pump_id_ff, adc_one_ff, adc_four_ff, retry_ff;
   logic        suppress_ff;
   logic        fv, fr, qv, qr;
   job_type     fj, qj;
   logic [7:0]  tx, slot, seq;
   logic        lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_id_ff <= 32'd1; pump_id_ff <= 16'd9999; adc_one_ff <= '0;
         adc_four_ff <= '0; suppress_ff <= 1'b0; retry_ff <= 16'd1200;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MASTER_ID:  master_id_ff <= csr_wdata;
            REG_PUMP_ID:    pump_id_ff   <= csr_wdata[15:0];
            REG_ADC_ONE:    adc_one_ff   <= csr_wdata[15:0];
            REG_ADC_FOUR:   adc_four_ff  <= csr_wdata[15:0];
            REG_SUPPRESS:   suppress_ff  <= csr_wdata[0];
            REG_JOIN_RETRY: retry_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   pnlr_front #(.MaxPacket(MaxPacket)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .action(req_tuser), .rx_byte(req_tdata), .rx_last(req_tlast),
      .master_id(master_id_ff), .pump_id(pump_id_ff), .suppress_ack(suppress_ff),
      .join_retry_ticks(retry_ff), .job_valid(fv), .job_ready(fr), .job(fj)
   );

   pnlr_queue u_queue (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
      .rd_valid(qv), .rd_ready(qr), .rd_job(qj)
   );

   pnlr_back u_back (
      .clock, .reset, .job_valid(qv), .job_ready(qr), .job(qj),
      .master_id(master_id_ff), .pump_id(pump_id_ff), .adc_one(adc_one_ff),
      .adc_four(adc_four_ff), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .kind(rsp_tuser), .tx_byte(tx), .run_last(rsp_tlast), .slot_number(slot),
      .command_state(lvl), .sequence_res(seq)
   );

   assign rsp_tdata = {7'd0, qj.acks, qj.cmds, qj.foreign, qj.bad_crc, seq, lvl, slot, tx};

   a_no_tx_in_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_TX |-> rsp_tdata[7:0] == 8'h00)
      else $error("status result carries a tx byte");
   a_slot_before_join: assert property (@(posedge clock) disable iff (reset)
      !u_front.joined_ff |-> u_front.slot_ff == SLOT_NONE)
      else $error("slot set while not joined");
   a_ack_only_after_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_COMMAND && !rsp_tlast |=>
      rsp_tvalid && rsp_tuser == KIND_TX)
      else $error("command not followed by its ack frame");
endmodule

@@ tb/tb_pump_node_link_responder.sv @@
// Self-checking testbench for the pump node link responder.
module tb_pump_node_link_responder import pnlr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PKT  = 64;
   localparam logic [2:0] NO_KIND = 3'd7;  // row without a typed-in kind
   localparam int DRAIN    = 10;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  tx;
      logic        last;
      logic [7:0]  slot;
      logic        level;
      logic [7:0]  seq;
      logic [31:0] bad_crc;
      logic [31:0] foreign;
      logic [31:0] cmds;
      logic [31:0] acks;
      logic [2:0]  typed;
   } result_type;

   typedef enum logic [1:0] {ROW_TICKS, ROW_PKT} row_op_type;

   typedef struct {
      row_op_type op;
      int         count;    // ticks, or packet length
      logic [7:0] ver;
      logic [7:0] ptype;
      logic       master_ok;
      logic [7:0] slot;
      logic [7:0] seq;
      logic [7:0] b8;
      logic [7:0] b9;
      logic [7:0] b10;
      logic       crc_ok;
      logic       tick_mid;
      logic [2:0] kind;
   } row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = 0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [159:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [2:0]   csr_index = 0;
   logic [31:0]  csr_wdata = 0;

   pump_node_link_responder dut (.*);

   // predictor state
   logic [31:0] m_master;
   logic [15:0] m_pump, m_adc1, m_adc4, m_retry;
   logic        m_suppress;
   logic [7:0]  m_hdr[HDR_DEPTH];
   int          m_count;
   logic [15:0] m_crc;
   logic        m_joined;
   logic [7:0]  m_slot;
   int          m_timer;
   logic [31:0] m_bad_crc, m_foreign, m_cmds, m_acks;

   result_type  pending[$];
   result_type  awaited[$];
   logic [2:0]  typed_q[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_results = 0;
   logic        idle_on = 1;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #400us;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ 16'h1021;
         else r = {r[14:0], 1'b0};
      end
      return r;
   endfunction

   function automatic void add_result(logic [2:0] kind, logic [7:0] tx, logic level,
                                      logic [7:0] seq);
      result_type r;
      r = '{default: 0};
      r.kind = kind;
      r.tx = tx;
      r.level = level;
      r.seq = seq;
      pending.push_back(r);
   endfunction

   function automatic void emit_frame(logic [7:0] ftype, logic [7:0] slot, logic [7:0] seq,
                                      byte_q_type pl, logic level, logic [7:0] cseq);
      byte_q_type f;
      logic [15:0] c;
      f = '{PROTO_VER, ftype, m_master[31:24], m_master[23:16], m_master[15:8],
            m_master[7:0], slot, seq};
      f = {f, pl};
      c = 16'hFFFF;
      foreach (f[i]) c = crc_next(c, f[i]);
      f.push_back(c[15:8]);
      f.push_back(c[7:0]);
      foreach (f[i]) add_result(KIND_TX, f[i], level, cseq);
   endfunction

   function automatic void close_packet();
      int          len;
      logic [31:0] mid;
      logic        level;
      len = m_count;
      m_count = 0;
      if (len < MIN_PACKET || len > MAX_PKT) begin
         m_crc = 16'hFFFF;
         add_result(KIND_BAD_LEN, 0, 0, 0);
         return;
      end
      if (m_crc != 0) begin
         m_crc = 16'hFFFF;
         m_bad_crc++;
         add_result(KIND_BAD_CRC, 0, 0, 0);
         return;
      end
      m_crc = 16'hFFFF;
      mid = {m_hdr[2], m_hdr[3], m_hdr[4], m_hdr[5]};
      if (m_hdr[0] != PROTO_VER || mid != m_master) begin
         m_foreign++;
         add_result(KIND_FOREIGN, 0, 0, 0);
      end else if (!m_joined) begin
         if (m_hdr[1] == T_JOIN_ACC && len >= 13 && {m_hdr[8], m_hdr[9]} == m_pump) begin
            m_slot = m_hdr[10];
            m_joined = 1;
            add_result(KIND_JOINED, 0, 0, 0);
         end else begin
            add_result(KIND_IGNORED, 0, 0, 0);
         end
      end else if (m_hdr[1] != T_LEVEL || m_hdr[6] != m_slot) begin
         add_result(KIND_IGNORED, 0, 0, 0);
      end else begin
         level = (m_hdr[8] != 0);
         m_cmds++;
         add_result(KIND_COMMAND, 0, level, m_hdr[7]);
         if (!m_suppress) begin
            m_acks++;
            emit_frame(T_ACK, m_slot, m_hdr[7],
                       '{{7'd0, level}, 8'h00, 8'h00, m_adc1[15:8], m_adc1[7:0],
                         m_adc4[15:8], m_adc4[7:0]}, level, m_hdr[7]);
         end
      end
   endfunction

   // Works out the results of one accepted request.
   function automatic void model_request(logic act, logic [7:0] b, logic last,
                                         logic [2:0] typed);
      pending.delete();
      if (act) begin
         if (!m_joined) begin
            if (m_timer != 0) m_timer--;
            else begin
               m_timer = m_retry;
               emit_frame(T_JOIN_REQ, SLOT_NONE, 0, '{m_pump[15:8], m_pump[7:0]}, 0, 0);
            end
         end
      end else begin
         if (m_count < HDR_DEPTH) m_hdr[m_count] = b;
         if (m_count <= MAX_PKT) m_count++;
         m_crc = crc_next(m_crc, b);
         if (last) close_packet();
      end
      foreach (pending[k]) begin
         pending[k].last = (k == pending.size() - 1);
         pending[k].slot = m_slot;
         pending[k].bad_crc = m_bad_crc;
         pending[k].foreign = m_foreign;
         pending[k].cmds = m_cmds;
         pending[k].acks = m_acks;
         pending[k].typed = (k == 0) ? typed : NO_KIND;
         awaited.push_back(pending[k]);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         model_request(req_tuser, req_tdata, req_tlast, typed_q.pop_front());
   end

   always @(posedge clock) begin
      result_type e;
      logic       bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result kind %0d tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            e = awaited.pop_front();
            bad = rsp_tuser != e.kind || rsp_tdata[7:0] != e.tx || rsp_tlast != e.last
                  || rsp_tdata[15:8] != e.slot || rsp_tdata[16] != e.level
                  || rsp_tdata[24:17] != e.seq || rsp_tdata[56:25] != e.bad_crc
                  || rsp_tdata[88:57] != e.foreign || rsp_tdata[120:89] != e.cmds
                  || rsp_tdata[152:121] != e.acks
                  || (e.typed != NO_KIND && rsp_tuser != e.typed);
            if (bad) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp kind %0d tx %h last %b slot %0d lvl %b seq %0d",
                            " tot %0d %0d %0d %0d (row kind %0d)",
                            " | got kind %0d last %b tdata %h"},
                     e.kind, e.tx, e.last, e.slot, e.level, e.seq, e.bad_crc, e.foreign,
                     e.cmds, e.acks, e.typed, rsp_tuser, rsp_tlast, rsp_tdata);
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the block
   initial begin
      int w;
      int accepted;
      logic held;
      accepted = 0;
      held = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = idle_on ? $urandom_range(0, 3) : 0;
         if (!held && accepted == 150) begin
            w = 300;
            held = 1;
         end
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         accepted++;
      end
   end

   task automatic send_req(logic act, logic [7:0] b, logic last, logic [2:0] typed);
      int w;
      w = idle_on ? $urandom_range(0, 3) : 0;
      if (w > 0) begin
         req_tvalid <= 0;
         repeat (w) @(posedge clock);
      end
      typed_q.push_back(typed);
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_req(1, $urandom_range(0, 255), $urandom_range(0, 1), NO_KIND);
   endtask

   function automatic byte_q_type build_pkt(int len, logic [7:0] ver, logic [7:0] ptype,
                                       logic master_ok, logic [7:0] slot, logic [7:0] seq,
                                       logic [7:0] b8, logic [7:0] b9, logic [7:0] b10,
                                       logic crc_ok);
      byte_q_type p;
      logic [7:0]  hdr[HDR_DEPTH];
      logic [31:0] mst;
      logic [15:0] c;
      mst = master_ok ? m_master : m_master ^ (32'd1 << $urandom_range(0, 31));
      hdr = '{ver, ptype, mst[31:24], mst[23:16], mst[15:8], mst[7:0], slot, seq, b8, b9, b10};
      if (len < 3) begin
         repeat (len) p.push_back($urandom_range(0, 255));
         return p;
      end
      for (int i = 0; i < len - 2; i++)
         p.push_back(i < HDR_DEPTH ? hdr[i] : 8'($urandom_range(0, 255)));
      c = 16'hFFFF;
      foreach (p[i]) c = crc_next(c, p[i]);
      if (!crc_ok) c ^= 16'd1 << $urandom_range(0, 15);
      p.push_back(c[15:8]);
      p.push_back(c[7:0]);
      return p;
   endfunction

   task automatic send_pkt(byte_q_type p, logic [2:0] typed, logic tick_mid);
      foreach (p[i]) begin
         if (tick_mid && i == 3) send_ticks(2);
         send_req(0, p[i], i == p.size() - 1, (i == p.size() - 1) ? typed : NO_KIND);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_MASTER_ID:  m_master = val;
         REG_PUMP_ID:    m_pump = val[15:0];
         REG_ADC_ONE:    m_adc1 = val[15:0];
         REG_ADC_FOUR:   m_adc4 = val[15:0];
         REG_SUPPRESS:   m_suppress = val[0];
         REG_JOIN_RETRY: m_retry = val[15:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic walk_rows(row_type rows[$]);
      foreach (rows[i]) begin
         if (rows[i].op == ROW_TICKS) send_ticks(rows[i].count);
         else send_pkt(build_pkt(rows[i].count, rows[i].ver, rows[i].ptype,
                                 rows[i].master_ok, rows[i].slot, rows[i].seq, rows[i].b8,
                                 rows[i].b9, rows[i].b10, rows[i].crc_ok),
                       rows[i].kind, rows[i].tick_mid);
      end
   endtask

   // one random packet or burst of ticks; mostly well-formed traffic
   task automatic random_traffic();
      int r;
      logic [15:0] wrong_pump;
      r = $urandom_range(0, 19);
      wrong_pump = m_pump ^ 16'($urandom_range(1, 65535));
      // join-accepts before joining always name another pump
      if (!m_joined && r < 8)
         send_pkt(build_pkt($urandom_range(10, 20), PROTO_VER, T_JOIN_ACC, 1,
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            wrong_pump[15:8], wrong_pump[7:0],
                            $urandom_range(0, 255), 1),
                  NO_KIND, 0);
      else if (r < 12)
         send_pkt(build_pkt($urandom_range(11, 22), PROTO_VER, T_LEVEL, 1, m_slot,
                            $urandom_range(0, 255),
                            $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00,
                            $urandom_range(0, 255), $urandom_range(0, 255), 1),
                  NO_KIND, $urandom_range(0, 7) == 0);
      else if (r == 12)
         send_pkt(build_pkt($urandom_range(11, 16), PROTO_VER, T_LEVEL, 1,
                            m_slot ^ 8'($urandom_range(1, 255)), $urandom_range(0, 255),
                            1, 0, 0, 1), NO_KIND, 0);
      else if (r == 13)
         send_pkt(build_pkt($urandom_range(10, 16), PROTO_VER, $urandom_range(0, 255), 1,
                            m_slot, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255), 1), NO_KIND, 0);
      else if (r == 14)
         send_pkt(build_pkt($urandom_range(10, 20), PROTO_VER, T_LEVEL, 1, m_slot, 0, 1, 0,
                            0, 0), NO_KIND, 0);
      else if (r == 15)
         send_pkt(build_pkt($urandom_range(10, 16),
                            $urandom_range(0, 1) ? 8'($urandom_range(2, 255)) : PROTO_VER,
                            T_LEVEL, 0, m_slot, 0, 1, 0, 0, 1), NO_KIND, 0);
      else if (r == 16)
         send_pkt(build_pkt($urandom_range(1, 9), PROTO_VER, T_LEVEL, 1, m_slot, 0, 1, 0,
                            0, 1), NO_KIND, 0);
      else if (r == 17)
         send_pkt(build_pkt($urandom_range(65, 70), PROTO_VER, T_LEVEL, 1, m_slot, 0, 1, 0,
                            0, 1), NO_KIND, 0);
      else if (r == 18)
         send_ticks($urandom_range(1, 4));
      else
         send_pkt(build_pkt($urandom_range(1, 20), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 1),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 1)), NO_KIND, 0);
   endtask

   initial begin
      row_type pre_join[$];
      row_type join_rows[$];
      int      target;
      m_master = 1; m_pump = 9999; m_adc1 = 0; m_adc4 = 0; m_suppress = 0; m_retry = 1200;
      foreach (m_hdr[i]) m_hdr[i] = 0;
      m_count = 0; m_crc = 16'hFFFF; m_joined = 0; m_slot = SLOT_NONE; m_timer = 0;
      m_bad_crc = 0; m_foreign = 0; m_cmds = 0; m_acks = 0;

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(REG_MASTER_ID, 32'hFFFF_FFFF);
      write_reg(REG_PUMP_ID, 16'h0000);
      write_reg(REG_ADC_ONE, 16'h0000);
      write_reg(REG_ADC_FOUR, 16'hFFFF);
      write_reg(REG_SUPPRESS, 0);
      write_reg(REG_JOIN_RETRY, 1);

      pre_join = '{
         '{ROW_TICKS, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_TX},
         '{ROW_TICKS, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_KIND},
         '{ROW_PKT, 9, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 0, 0, 1, 1, 0, KIND_BAD_LEN},
         '{ROW_PKT, 66, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 0, 0, 1, 1, 0, KIND_BAD_LEN},
         '{ROW_PKT, 12, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 0, 0, 1, 0, 0, KIND_BAD_CRC},
         '{ROW_PKT, 13, 8'h02, T_JOIN_ACC, 1, 0, 0, 0, 0, 1, 1, 0, KIND_FOREIGN},
         '{ROW_PKT, 13, PROTO_VER, T_JOIN_ACC, 0, 0, 0, 0, 0, 1, 1, 0, KIND_FOREIGN},
         '{ROW_PKT, 13, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 8'hFF, 8'hFF, 1, 1, 0, KIND_IGNORED},
         '{ROW_PKT, 12, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 0, 0, 1, 1, 0, KIND_IGNORED},
         '{ROW_PKT, 16, PROTO_VER, T_LEVEL, 1, 0, 0, 0, 0, 1, 1, 0, KIND_IGNORED}
      };
      walk_rows(pre_join);
      drain();

      // random traffic before joining; the join itself is left to the table
      write_reg(REG_PUMP_ID, 16'hFFFF);
      write_reg(REG_JOIN_RETRY, $urandom_range(1, 3));
      target = n_sent + 50;
      while (n_sent < target) random_traffic();
      drain();

      join_rows = '{
         '{ROW_PKT, 13, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 8'hFF, 8'hFF, 5, 1, 1, KIND_JOINED},
         '{ROW_PKT, 13, PROTO_VER, T_JOIN_ACC, 1, 0, 0, 8'hFF, 8'hFF, 6, 1, 0, KIND_IGNORED},
         '{ROW_PKT, 12, PROTO_VER, T_LEVEL, 1, 4, 0, 1, 0, 0, 1, 0, KIND_IGNORED},
         '{ROW_PKT, 11, PROTO_VER, T_LEVEL, 1, 5, 8'hFF, 1, 0, 0, 1, 0, KIND_COMMAND},
         '{ROW_PKT, 64, PROTO_VER, T_LEVEL, 1, 5, 0, 0, 0, 0, 1, 0, KIND_COMMAND},
         '{ROW_TICKS, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_KIND}
      };
      walk_rows(join_rows);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(REG_SUPPRESS, ph == 2);
         write_reg(REG_ADC_ONE, (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
         write_reg(REG_ADC_FOUR, (ph == 1) ? 16'h0000 : 16'($urandom_range(0, 65535)));
         if (ph == 3) write_reg(REG_MASTER_ID, 32'd1);
         if (ph == 4) write_reg(REG_MASTER_ID, $urandom);
         if (ph == 4) write_reg(REG_JOIN_RETRY, 16'hFFFF);
         idle_on = (ph != 3);
         target = n_sent + 20;
         while (n_sent < target) random_traffic();
         drain();
      end
      idle_on = 1;

      if (errors == 0 && awaited.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
